### hw/rtl/csc_pkg.sv
// Shared types and constants for the cliff sensor classifier.
`timescale 1ns / 1ps
package csc_pkg;

   localparam int ReadingWidth = 12;
   localparam int MarginWidth  = 9;
   localparam int CalWidth     = 32;
   localparam int CodeWidth    = 4;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int RegIdxWidth  = 3;

   localparam logic [CalWidth-1:0]     CAL_ERASED   = '1;
   localparam logic [MarginWidth-1:0]  MARGIN_MIN   = 9'd50;
   localparam logic [MarginWidth-1:0]  MARGIN_MAX   = 9'd300;
   localparam logic [MarginWidth-1:0]  MARGIN_RESET = 9'd100;
   localparam logic [ReadingWidth-1:0] BASE_RESET   = 12'd3400;

   // Register indexes (byte address = 4 * index)
   localparam logic [RegIdxWidth-1:0] REG_ENABLE  = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_MARGIN  = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_BASE    = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_CAL_LF  = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_CAL_LB  = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_CAL_RF  = 3'd5;
   localparam logic [RegIdxWidth-1:0] REG_CAL_RB  = 3'd6;

   // Sensor pattern bits
   localparam logic [3:0] PAT_NONE = 4'h0;
   localparam logic [3:0] PAT_LF   = 4'h1;
   localparam logic [3:0] PAT_LB   = 4'h2;
   localparam logic [3:0] PAT_RB   = 4'h4;
   localparam logic [3:0] PAT_RF   = 4'h8;
   localparam logic [3:0] PAT_LEFT  = PAT_LF | PAT_LB;
   localparam logic [3:0] PAT_BACK  = PAT_LB | PAT_RB;
   localparam logic [3:0] PAT_RIGHT = PAT_RB | PAT_RF;
   localparam logic [3:0] PAT_FRONT = PAT_LF | PAT_RF;
   localparam logic [3:0] PAT_ALL   = 4'hF;

   // Direction codes
   localparam logic [CodeWidth-1:0] CODE_NONE  = 4'd0;
   localparam logic [CodeWidth-1:0] CODE_LF    = 4'd1;
   localparam logic [CodeWidth-1:0] CODE_LB    = 4'd2;
   localparam logic [CodeWidth-1:0] CODE_RB    = 4'd3;
   localparam logic [CodeWidth-1:0] CODE_RF    = 4'd4;
   localparam logic [CodeWidth-1:0] CODE_LEFT  = 4'd5;
   localparam logic [CodeWidth-1:0] CODE_BACK  = 4'd6;
   localparam logic [CodeWidth-1:0] CODE_RIGHT = 4'd7;
   localparam logic [CodeWidth-1:0] CODE_FRONT = 4'd8;
   localparam logic [CodeWidth-1:0] CODE_OTHER = 4'd9;

   typedef struct packed {
      logic                    sample_valid;
      logic [ReadingWidth-1:0] left_front;
      logic [ReadingWidth-1:0] left_back;
      logic [ReadingWidth-1:0] right_front;
      logic [ReadingWidth-1:0] right_back;
   } csc_req_type;

   typedef struct packed {
      logic [CodeWidth-1:0] cliff_code;
      logic                 suspend_flag;
      logic                 cliff_changed;
      logic                 suspend_changed;
      logic                 stop_request;
   } csc_rsp_type;

   typedef struct packed {
      logic                    enable;
      logic [MarginWidth-1:0]  margin;
      logic [ReadingWidth-1:0] base_level;
      logic [CalWidth-1:0]     cal_left_front;
      logic [CalWidth-1:0]     cal_left_back;
      logic [CalWidth-1:0]     cal_right_front;
      logic [CalWidth-1:0]     cal_right_back;
   } csc_cfg_type;

endpackage

### hw/rtl/csc_regs.sv
// APB-style configuration register file for the cliff sensor classifier.
`timescale 1ns / 1ps
module csc_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [csc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [csc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [csc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output csc_pkg::csc_cfg_type               cfg
);
   import csc_pkg::*;

   csc_cfg_type            cfg_ff;
   csc_cfg_type            cfg_in;
   logic                   wr_en;
   logic [RegIdxWidth-1:0] idx;
   logic [MarginWidth-1:0] margin_wr;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[CsrAddrWidth-1:2];
   assign margin_wr  = csr_pwdata[MarginWidth-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ENABLE: cfg_in.enable = csr_pwdata[0];
            REG_MARGIN: begin
               if ((margin_wr >= MARGIN_MIN) && (margin_wr <= MARGIN_MAX)) begin
                  cfg_in.margin = margin_wr;
               end
            end
            REG_BASE:   cfg_in.base_level      = csr_pwdata[ReadingWidth-1:0];
            REG_CAL_LF: cfg_in.cal_left_front  = csr_pwdata;
            REG_CAL_LB: cfg_in.cal_left_back   = csr_pwdata;
            REG_CAL_RF: cfg_in.cal_right_front = csr_pwdata;
            REG_CAL_RB: cfg_in.cal_right_back  = csr_pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b1;
         cfg_ff.margin          <= MARGIN_RESET;
         cfg_ff.base_level      <= BASE_RESET;
         cfg_ff.cal_left_front  <= CAL_ERASED;
         cfg_ff.cal_left_back   <= CAL_ERASED;
         cfg_ff.cal_right_front <= CAL_ERASED;
         cfg_ff.cal_right_back  <= CAL_ERASED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_ENABLE: csr_prdata = {{(CsrDataWidth-1){1'b0}}, cfg_ff.enable};
         REG_MARGIN: csr_prdata = {{(CsrDataWidth-MarginWidth){1'b0}}, cfg_ff.margin};
         REG_BASE:   csr_prdata = {{(CsrDataWidth-ReadingWidth){1'b0}}, cfg_ff.base_level};
         REG_CAL_LF: csr_prdata = cfg_ff.cal_left_front;
         REG_CAL_LB: csr_prdata = cfg_ff.cal_left_back;
         REG_CAL_RF: csr_prdata = cfg_ff.cal_right_front;
         REG_CAL_RB: csr_prdata = cfg_ff.cal_right_back;
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/csc_classify.sv
// Threshold compare, pattern decode and suspend logic for one transaction.
`timescale 1ns / 1ps
module csc_classify (
   input  csc_pkg::csc_cfg_type                cfg,
   input  csc_pkg::csc_req_type                req,
   input  logic [csc_pkg::CodeWidth-1:0]       held_code,
   input  logic                                held_suspend,
   output csc_pkg::csc_rsp_type                rsp
);
   import csc_pkg::*;

   logic                 active;
   logic [3:0]           pat;
   logic [CodeWidth-1:0] code;
   logic                 susp;
   logic                 all_above;
   logic                 cchg;
   logic                 schg;

   function automatic logic over_threshold(
      input logic [ReadingWidth-1:0] reading,
      input logic [CalWidth-1:0]     cal,
      input logic [MarginWidth-1:0]  margin,
      input logic [ReadingWidth-1:0] base
   );
      logic [ReadingWidth:0] sum;
      logic                  use_base;
      sum      = {1'b0, reading} + {{(ReadingWidth+1-MarginWidth){1'b0}}, margin};
      use_base = (cal == CAL_ERASED) ||
                 (cal < {{(CalWidth-ReadingWidth){1'b0}}, base});
      if (use_base) begin
         return reading > base;
      end
      return {{(CalWidth-ReadingWidth-1){1'b0}}, sum} > cal;
   endfunction

   assign active = cfg.enable & req.sample_valid;

   always_comb begin
      pat = PAT_NONE;
      if (over_threshold(req.left_front, cfg.cal_left_front, cfg.margin, cfg.base_level))
         pat = pat | PAT_LF;
      if (over_threshold(req.left_back, cfg.cal_left_back, cfg.margin, cfg.base_level))
         pat = pat | PAT_LB;
      if (over_threshold(req.right_back, cfg.cal_right_back, cfg.margin, cfg.base_level))
         pat = pat | PAT_RB;
      if (over_threshold(req.right_front, cfg.cal_right_front, cfg.margin, cfg.base_level))
         pat = pat | PAT_RF;
   end

   assign all_above = (req.left_front > cfg.base_level) && (req.left_back > cfg.base_level) &&
                      (req.right_back > cfg.base_level) && (req.right_front > cfg.base_level);

   always_comb begin
      code = held_code;
      susp = held_suspend;
      if (active) begin
         unique case (pat)
            PAT_NONE:  code = CODE_NONE;
            PAT_LF:    code = CODE_LF;
            PAT_LB:    code = CODE_LB;
            PAT_RB:    code = CODE_RB;
            PAT_RF:    code = CODE_RF;
            PAT_LEFT:  code = CODE_LEFT;
            PAT_BACK:  code = CODE_BACK;
            PAT_RIGHT: code = CODE_RIGHT;
            PAT_FRONT: code = CODE_FRONT;
            PAT_ALL:   code = held_code;
            default:   code = CODE_OTHER;
         endcase
         if (pat == PAT_NONE) begin
            susp = 1'b0;
         end
         if (all_above) begin
            susp = 1'b1;
         end
      end
   end

   assign cchg = active && (code != held_code);
   assign schg = active && (susp != held_suspend);

   assign rsp.cliff_code      = code;
   assign rsp.suspend_flag    = susp;
   assign rsp.cliff_changed   = cchg;
   assign rsp.suspend_changed = schg;
   assign rsp.stop_request    = cchg && (code != CODE_NONE);

endmodule

### hw/rtl/cliff_sensor_classifier_top.sv
// Top level of the cliff sensor classifier: input and result registers, held state.
`timescale 1ns / 1ps
// Classifies four floor-sensor readings per transaction into a cliff direction
// code, a suspend flag, change events and a stop request. One result comes out
// for every transaction. It passes the input register, the single classify
// stage and the result register, which offers it on rsp_. A transaction can
// be accepted every cycle while the result register is free. The held code
// and suspend flag update when a transaction leaves the input register, so
// back-to-back transactions see the state left by the one before. Disabled
// or stale transactions return the held code and flag with no events. Registers
// are on the csr_ port at byte address 4 * index: enable, margin, base_level,
// then the four calibrations (LF, LB, RF, RB). Margin writes outside 50..300
// are dropped. Write configuration only while no transaction is in flight.
module cliff_sensor_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  csc_pkg::csc_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output csc_pkg::csc_rsp_type               rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [csc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [csc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [csc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import csc_pkg::*;

   csc_cfg_type          cfg;
   csc_rsp_type          rsp_calc;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   csc_req_type          in_data_ff;
   csc_req_type          in_data_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   csc_rsp_type          out_data_ff;
   csc_rsp_type          out_data_in;
   logic [CodeWidth-1:0] held_code_ff;
   logic [CodeWidth-1:0] held_code_in;
   logic                 held_susp_ff;
   logic                 held_susp_in;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   csc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   csc_classify u_classify (
      .cfg          (cfg),
      .req          (in_data_ff),
      .held_code    (held_code_ff),
      .held_suspend (held_susp_ff),
      .rsp          (rsp_calc)
   );

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign in_data_in   = req_take ? req_data : in_data_ff;
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);
   assign out_data_in  = advance ? rsp_calc : out_data_ff;
   assign held_code_in = advance ? rsp_calc.cliff_code : held_code_ff;
   assign held_susp_in = advance ? rsp_calc.suspend_flag : held_susp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_code_ff <= CODE_NONE;
         held_susp_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         held_code_ff <= held_code_in;
         held_susp_ff <= held_susp_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### bench/testbench.sv
// Self-checking testbench for the cliff sensor classifier top level.
`timescale 1ns / 1ps
module testbench;
   import csc_pkg::*;

   localparam int ReadingMax  = (1 << ReadingWidth) - 1;
   localparam int IdlePercent = 21;
   localparam int HoldCycles  = 80;
   localparam int PhaseTicks  = 150;
   localparam int MaxReports  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   csc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   csc_rsp_type rsp_data;

   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   cliff_sensor_classifier_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // classifier shadow: configuration and held state
   csc_cfg_type          shadow_cfg = '{enable: 1'b1, margin: MARGIN_RESET,
                                        base_level: BASE_RESET,
                                        cal_left_front: CAL_ERASED,
                                        cal_left_back: CAL_ERASED,
                                        cal_right_front: CAL_ERASED,
                                        cal_right_back: CAL_ERASED};
   logic [CodeWidth-1:0] held_code = CODE_NONE;
   logic                 held_suspend = 1'b0;

   csc_req_type queued_ticks[$];
   csc_rsp_type expected_verdicts[$];

   bit no_idle       = 1'b0;
   bit req_taken     = 1'b0;
   int hold_requests = 0;
   int mismatches    = 0;
   int n_ticks       = 0;
   int n_writes      = 0;
   int n_stops       = 0;
   int n_susp_events = 0;
   logic [15:0] codes_seen = '0;

   function automatic longint threshold_of(logic [CalWidth-1:0] cal);
      if (cal == CAL_ERASED || cal < shadow_cfg.base_level)
         return longint'(shadow_cfg.base_level);
      return longint'(cal) - longint'(shadow_cfg.margin);
   endfunction

   function automatic bit over(logic [ReadingWidth-1:0] reading, logic [CalWidth-1:0] cal);
      return longint'(reading) > threshold_of(cal);
   endfunction

   function automatic csc_rsp_type classify_tick(csc_req_type t);
      csc_rsp_type          r;
      logic [3:0]           pat;
      logic [CodeWidth-1:0] code;
      logic                 susp;
      r = '0;
      code = held_code;
      susp = held_suspend;
      if (shadow_cfg.enable && t.sample_valid) begin
         pat = PAT_NONE;
         if (over(t.left_front, shadow_cfg.cal_left_front)) pat |= PAT_LF;
         if (over(t.left_back, shadow_cfg.cal_left_back)) pat |= PAT_LB;
         if (over(t.right_back, shadow_cfg.cal_right_back)) pat |= PAT_RB;
         if (over(t.right_front, shadow_cfg.cal_right_front)) pat |= PAT_RF;
         case (pat)
            PAT_NONE:  code = CODE_NONE;
            PAT_LF:    code = CODE_LF;
            PAT_LB:    code = CODE_LB;
            PAT_RB:    code = CODE_RB;
            PAT_RF:    code = CODE_RF;
            PAT_LEFT:  code = CODE_LEFT;
            PAT_BACK:  code = CODE_BACK;
            PAT_RIGHT: code = CODE_RIGHT;
            PAT_FRONT: code = CODE_FRONT;
            PAT_ALL:   code = held_code;
            default:   code = CODE_OTHER;
         endcase
         // no-bit clears first, lift test may set it again
         if (pat == PAT_NONE) susp = 1'b0;
         if (t.left_front > shadow_cfg.base_level && t.left_back > shadow_cfg.base_level &&
             t.right_back > shadow_cfg.base_level && t.right_front > shadow_cfg.base_level)
            susp = 1'b1;
         r.cliff_changed   = (code != held_code);
         r.suspend_changed = (susp != held_suspend);
         r.stop_request    = r.cliff_changed && (code != CODE_NONE);
         held_code    = code;
         held_suspend = susp;
      end
      r.cliff_code   = code;
      r.suspend_flag = susp;
      return r;
   endfunction

   function automatic logic [ReadingWidth-1:0] reading_for(bit above, logic [CalWidth-1:0] cal);
      longint thr;
      longint lo;
      longint hi;
      thr = threshold_of(cal);
      if (above) begin
         if (thr >= ReadingMax) return ReadingWidth'($urandom_range(ReadingMax));
         lo = (thr < 0) ? 0 : thr + 1;
         hi = ($urandom_range(1) == 1) ? ReadingMax : ((lo + 7 > ReadingMax) ? ReadingMax : lo + 7);
      end else begin
         if (thr < 0) return ReadingWidth'($urandom_range(ReadingMax));
         hi = (thr > ReadingMax) ? ReadingMax : thr;
         lo = ($urandom_range(1) == 1) ? 0 : ((hi < 7) ? 0 : hi - 7);
      end
      return ReadingWidth'($urandom_range(int'(hi), int'(lo)));
   endfunction

   function automatic csc_req_type make_tick();
      csc_req_type t;
      int          roll;
      logic [3:0]  want;
      roll = $urandom_range(99);
      t.sample_valid = (roll >= 5);
      if (roll < 12) begin
         t.left_front  = ReadingWidth'($urandom_range(ReadingMax));
         t.left_back   = ReadingWidth'($urandom_range(ReadingMax));
         t.right_front = ReadingWidth'($urandom_range(ReadingMax));
         t.right_back  = ReadingWidth'($urandom_range(ReadingMax));
      end else if (roll < 25 && shadow_cfg.base_level < ReadingMax) begin
         // lifted: every reading above the base level
         t.left_front  = ReadingWidth'($urandom_range(ReadingMax, shadow_cfg.base_level + 1));
         t.left_back   = ReadingWidth'($urandom_range(ReadingMax, shadow_cfg.base_level + 1));
         t.right_front = ReadingWidth'($urandom_range(ReadingMax, shadow_cfg.base_level + 1));
         t.right_back  = ReadingWidth'($urandom_range(ReadingMax, shadow_cfg.base_level + 1));
      end else begin
         want = 4'($urandom_range(15));
         t.left_front  = reading_for(want[0], shadow_cfg.cal_left_front);
         t.left_back   = reading_for(want[1], shadow_cfg.cal_left_back);
         t.right_back  = reading_for(want[2], shadow_cfg.cal_right_back);
         t.right_front = reading_for(want[3], shadow_cfg.cal_right_front);
      end
      return t;
   endfunction

   function automatic csc_req_type tick(bit v, int lf, int lb, int rf, int rb);
      csc_req_type t;
      t.sample_valid = v;
      t.left_front   = ReadingWidth'(lf);
      t.left_back    = ReadingWidth'(lb);
      t.right_front  = ReadingWidth'(rf);
      t.right_back   = ReadingWidth'(rb);
      return t;
   endfunction

   function automatic logic [CalWidth-1:0] random_cal();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) return CAL_ERASED;
      if (roll < 24) return (shadow_cfg.base_level == 0) ? '0 :
                            CalWidth'($urandom_range(shadow_cfg.base_level - 1));
      if (roll < 30) return $urandom;
      return CalWidth'($urandom_range(ReadingMax + MARGIN_MAX, shadow_cfg.base_level));
   endfunction

   task automatic note_failure(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("%s", msg);
   endtask

   task automatic csr_write(logic [RegIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      case (idx)
         REG_ENABLE: shadow_cfg.enable = value[0];
         REG_MARGIN: begin
            if (value[MarginWidth-1:0] >= MARGIN_MIN && value[MarginWidth-1:0] <= MARGIN_MAX)
               shadow_cfg.margin = value[MarginWidth-1:0];
         end
         REG_BASE:   shadow_cfg.base_level = value[ReadingWidth-1:0];
         REG_CAL_LF: shadow_cfg.cal_left_front = value;
         REG_CAL_LB: shadow_cfg.cal_left_back = value;
         REG_CAL_RF: shadow_cfg.cal_right_front = value;
         REG_CAL_RB: shadow_cfg.cal_right_back = value;
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic drain();
      while (queued_ticks.size() != 0 || expected_verdicts.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_ticks(int count);
      csc_req_type t;
      int          live;
      live = 0;
      while (live < count) begin
         t = make_tick();
         queued_ticks.push_back(t);
         if (t.sample_valid) live++;
      end
   endtask

   task automatic set_phase_config(int p);
      case (p)
         0: begin
            csr_write(REG_MARGIN, MARGIN_MIN);
            csr_write(REG_BASE, ReadingMax);
         end
         1: begin
            csr_write(REG_MARGIN, MARGIN_MAX);
            csr_write(REG_BASE, 0);
         end
         2: begin
            csr_write(REG_MARGIN, MARGIN_MIN - 1);
            csr_write(REG_MARGIN, 32'h1FF);
            csr_write(REG_MARGIN, MARGIN_MAX + 1);
            csr_write(REG_BASE, 200);
         end
         3: begin
            csr_write(REG_MARGIN, MARGIN_RESET);
            csr_write(REG_BASE, BASE_RESET);
         end
         default: begin
            csr_write(REG_MARGIN, $urandom_range(350));
            csr_write(REG_BASE, $urandom_range(ReadingMax));
         end
      endcase
      csr_write(REG_CAL_LF, random_cal());
      csr_write(REG_CAL_LB, random_cal());
      csr_write(REG_CAL_RF, random_cal());
      csr_write(REG_CAL_RB, random_cal());
      case (p)
         1: begin
            // calibration below margin: threshold would go negative
            csr_write(REG_CAL_LF, 0);
            csr_write(REG_CAL_LB, 150);
         end
         2: begin
            csr_write(REG_CAL_LF, shadow_cfg.base_level);
            csr_write(REG_CAL_RB, 32'hFFFF_FFFE);
         end
         3: begin
            csr_write(REG_CAL_RF, CAL_ERASED);
         end
         default: ;
      endcase
   endtask

   // input driver
   always @(negedge clock) begin : drive_ticks
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_ticks.size() != 0 && (no_idle || $urandom_range(99) >= IdlePercent)) begin
            req_valid <= 1'b1;
            req_data  <= queued_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold-off on request
   always @(negedge clock) begin : drive_stall
      static int holds_served = 0;
      static int stall_left   = 0;
      if (hold_requests != holds_served) begin
         holds_served++;
         stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IdlePercent);
      end
   end

   always @(posedge clock) begin : observe
      csc_rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         want = classify_tick(req_data);
         expected_verdicts.push_back(want);
         n_ticks++;
         codes_seen[want.cliff_code] = 1'b1;
         if (want.stop_request) n_stops++;
         if (want.suspend_changed) n_susp_events++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            note_failure($sformatf("[%0t] result with no transaction outstanding", $time));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.cliff_code !== want.cliff_code ||
                rsp_data.suspend_flag !== want.suspend_flag ||
                rsp_data.cliff_changed !== want.cliff_changed ||
                rsp_data.suspend_changed !== want.suspend_changed ||
                rsp_data.stop_request !== want.stop_request)
               note_failure($sformatf({"[%0t] mismatch: expected code=%0d susp=%0b cchg=%0b ",
                  "schg=%0b stop=%0b, got code=%0d susp=%0b cchg=%0b schg=%0b stop=%0b"},
                  $time, want.cliff_code, want.suspend_flag, want.cliff_changed,
                  want.suspend_changed, want.stop_request, rsp_data.cliff_code,
                  rsp_data.suspend_flag, rsp_data.cliff_changed, rsp_data.suspend_changed,
                  rsp_data.stop_request));
         end
      end
   end

   initial begin : stimulus
      localparam int H = ReadingMax;
      localparam int B = BASE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: every sensor falls back to the base level
      queued_ticks.push_back(tick(1, 0, 0, 0, 0));
      queued_ticks.push_back(tick(1, H, 0, 0, 0));
      queued_ticks.push_back(tick(1, 0, H, 0, 0));
      queued_ticks.push_back(tick(1, 0, 0, 0, H));
      queued_ticks.push_back(tick(1, 0, 0, H, 0));
      queued_ticks.push_back(tick(1, H, H, 0, 0));
      queued_ticks.push_back(tick(1, 0, H, 0, H));
      queued_ticks.push_back(tick(1, 0, 0, H, H));
      queued_ticks.push_back(tick(1, H, 0, H, 0));
      queued_ticks.push_back(tick(1, H, 0, 0, H));
      queued_ticks.push_back(tick(1, 0, H, H, 0));
      queued_ticks.push_back(tick(1, H, H, 0, H));
      queued_ticks.push_back(tick(1, H, 0, 0, 0));
      queued_ticks.push_back(tick(1, H, H, H, H));
      queued_ticks.push_back(tick(0, 0, 0, 0, 0));
      queued_ticks.push_back(tick(1, H, 0, 0, 0));
      queued_ticks.push_back(tick(1, B, B, B, B));
      queued_ticks.push_back(tick(1, B + 1, B + 1, B + 1, B + 1));
      queued_ticks.push_back(tick(1, H, H, H, H));
      queued_ticks.push_back(tick(1, 0, 0, 0, 0));
      queued_ticks.push_back(tick(0, H, H, H, H));
      drain();

      for (int p = 0; p < 8; p++) begin
         set_phase_config(p);
         if (p == 3) no_idle = 1'b1;
         if (p == 4) begin
            queue_ticks(60);
            hold_requests++;
            drain();
            queue_ticks(PhaseTicks - 60);
         end else begin
            queue_ticks(PhaseTicks);
         end
         drain();
         no_idle = 1'b0;
         if (p == 3) begin
            csr_write(REG_ENABLE, 0);
            queue_ticks(30);
            drain();
            csr_write(REG_ENABLE, 1);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d transactions across %0d register writes (margin, base, enable,",
               n_ticks, n_writes);
      $display("calibration extremes); %0d stop requests, %0d suspend changes, codes seen %b",
               n_stops, n_susp_events, codes_seen[9:0]);
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d results outstanding", expected_verdicts.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
